// ----- rtl/core/ism_pkg.sv -----
// ----------------------------------------------------------------------------
// ism_pkg
// Shared types, codes and defaults of the integer stack machine core.
// ----------------------------------------------------------------------------
package ism_pkg;

  localparam int CFG_W    = 13;
  localparam int ACT_W    = 5;
  localparam int SLOT_W   = 4;
  localparam int TGT_W    = 12;
  localparam int DATA_W   = 32;

  localparam int DEF_STACK_DEPTH   = 256;
  localparam int DEF_SLOT_COUNT    = 16;
  localparam int DEF_PROGRAM_DEPTH = 4096;

  typedef enum logic [ACT_W-1:0] {
    OP_PUSH       = 5'd0,
    OP_LOAD       = 5'd1,
    OP_STORE_DECL = 5'd2,
    OP_STORE      = 5'd3,
    OP_ADD        = 5'd4,
    OP_SUB        = 5'd5,
    OP_MUL        = 5'd6,
    OP_DIV        = 5'd7,
    OP_MOD        = 5'd8,
    OP_LT         = 5'd9,
    OP_LE         = 5'd10,
    OP_GT         = 5'd11,
    OP_GE         = 5'd12,
    OP_EQ         = 5'd13,
    OP_NE         = 5'd14,
    OP_NEG        = 5'd15,
    OP_NOT        = 5'd16,
    OP_JUMP       = 5'd17,
    OP_JUMP_FALSE = 5'd18
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_UNDER   = 2'd1,
    ST_DIVZERO = 2'd2,
    ST_OVER    = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    ALU_ADD, ALU_SUB, ALU_MUL, ALU_DIV, ALU_MOD, ALU_LT, ALU_LE,
    ALU_GT, ALU_GE, ALU_EQ, ALU_NE, ALU_NEG, ALU_NOT
  } alu_op_t;

  typedef enum logic [2:0] {
    A_IDLE, A_ABSA, A_ABSB, A_DIV, A_FIX, A_MUL, A_DONE
  } alu_state_t;

  typedef enum logic [2:0] {
    S_IDLE, S_WRAP, S_READ, S_EXEC, S_ALU, S_PUT
  } core_state_t;

  typedef struct packed {
    logic              start;
    alu_op_t           op;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] result;
  } alu_rsp_t;

endpackage

// ----- rtl/core/ism_ram.sv -----
// ----------------------------------------------------------------------------
// ism_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module ism_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/ism_alu.sv -----
// ----------------------------------------------------------------------------
// ism_alu
// Shared 33-bit adder with a small sequencer: one-pass ops, bit-serial
// multiply and restoring signed divide and modulo.
// ----------------------------------------------------------------------------
module ism_alu
  import ism_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  alu_state_t        astate, astate_next;
  alu_op_t           op_r;
  logic [DATA_W-1:0] acc, quo, dvs, result;
  logic [4:0]        cnt;
  logic              sign_a, sign_b;

  logic [DATA_W:0]   x, y, sum;
  logic              sub;
  logic [DATA_W-1:0] rem_shift;
  logic              eq, lt;

  assign rem_shift = {acc[DATA_W-2:0], quo[DATA_W-1]};
  assign sum = x + (sub ? ~y : y) + {{DATA_W{1'b0}}, sub};
  assign eq  = (req.a == req.b);
  assign lt  = sum[DATA_W];

  // Operand selection for the shared adder.
  always_comb begin
    x   = '0;
    y   = '0;
    sub = 1'b0;
    unique case (astate)
      A_IDLE: begin
        unique case (req.op)
          ALU_ADD: begin
            x = {1'b0, req.a};
            y = {1'b0, req.b};
          end
          ALU_SUB: begin
            x   = {1'b0, req.a};
            y   = {1'b0, req.b};
            sub = 1'b1;
          end
          ALU_NEG: begin
            y   = {1'b0, req.a};
            sub = 1'b1;
          end
          default: begin
            x   = {req.a[DATA_W-1], req.a};
            y   = {req.b[DATA_W-1], req.b};
            sub = 1'b1;
          end
        endcase
      end
      A_ABSA: begin
        y   = {1'b0, quo};
        sub = 1'b1;
      end
      A_ABSB: begin
        y   = {1'b0, dvs};
        sub = 1'b1;
      end
      A_DIV: begin
        x   = {1'b0, rem_shift};
        y   = {1'b0, dvs};
        sub = 1'b1;
      end
      A_MUL: begin
        x = {1'b0, acc};
        y = {1'b0, dvs};
      end
      A_FIX: begin
        y   = {1'b0, (op_r == ALU_DIV) ? quo : acc};
        sub = 1'b1;
      end
      default: begin
        x = '0;
      end
    endcase
  end

  always_comb begin
    astate_next = astate;
    unique case (astate)
      A_IDLE: begin
        if (req.start) begin
          if (req.op == ALU_MUL) begin
            astate_next = A_MUL;
          end else if (req.op == ALU_DIV || req.op == ALU_MOD) begin
            astate_next = A_ABSA;
          end else begin
            astate_next = A_DONE;
          end
        end
      end
      A_ABSA: astate_next = A_ABSB;
      A_ABSB: astate_next = A_DIV;
      A_DIV:  if (cnt == 5'd31) astate_next = A_FIX;
      A_FIX:  astate_next = A_DONE;
      A_MUL:  if (cnt == 5'd31) astate_next = A_DONE;
      default: astate_next = A_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      astate <= A_IDLE;
    end else begin
      astate <= astate_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (astate)
      A_IDLE: begin
        if (req.start) begin
          op_r   <= req.op;
          acc    <= '0;
          quo    <= req.a;
          dvs    <= req.b;
          cnt    <= '0;
          sign_a <= req.a[DATA_W-1];
          sign_b <= req.b[DATA_W-1];
          unique case (req.op)
            ALU_ADD, ALU_SUB, ALU_NEG: result <= sum[DATA_W-1:0];
            ALU_LT:  result <= DATA_W'(lt);
            ALU_LE:  result <= DATA_W'(lt | eq);
            ALU_GT:  result <= DATA_W'(!(lt | eq));
            ALU_GE:  result <= DATA_W'(!lt);
            ALU_EQ:  result <= DATA_W'(eq);
            ALU_NE:  result <= DATA_W'(!eq);
            ALU_NOT: result <= DATA_W'(req.a == '0);
            default: result <= '0;
          endcase
        end
      end
      A_ABSA: if (sign_a) quo <= sum[DATA_W-1:0];
      A_ABSB: if (sign_b) dvs <= sum[DATA_W-1:0];
      A_DIV: begin
        // A set top bit is a borrow: the trial subtract did not fit.
        if (!sum[DATA_W]) begin
          acc <= sum[DATA_W-1:0];
          quo <= {quo[DATA_W-2:0], 1'b1};
        end else begin
          acc <= rem_shift;
          quo <= {quo[DATA_W-2:0], 1'b0};
        end
        cnt <= cnt + 5'd1;
      end
      A_MUL: begin
        if (quo[0]) begin
          acc <= sum[DATA_W-1:0];
        end
        quo <= {1'b0, quo[DATA_W-1:1]};
        dvs <= {dvs[DATA_W-2:0], 1'b0};
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          result <= quo[0] ? sum[DATA_W-1:0] : acc;
        end
      end
      A_FIX: begin
        // Quotient is negative when the signs differ, remainder follows the dividend.
        if (op_r == ALU_DIV) begin
          result <= (sign_a ^ sign_b) ? sum[DATA_W-1:0] : quo;
        end else begin
          result <= sign_a ? sum[DATA_W-1:0] : acc;
        end
      end
      default: begin
        cnt <= cnt;
      end
    endcase
  end

  assign rsp.done   = (astate == A_DONE);
  assign rsp.result = result;

endmodule

// ----- rtl/core/integer_stack_machine_core.sv -----
// ----------------------------------------------------------------------------
// integer_stack_machine_core
// Executes one 32-bit stack machine instruction per input beat.
// ----------------------------------------------------------------------------
// Input beats (action, slot_index, jump_target, immediate) are taken on
// in_valid while in_stall is low. Each beat yields one output beat with
// next_pc, top_value, stack_depth, status and done_res, held on out_valid
// until out_stall is low. program_length is written on cfg_valid/cfg_ready;
// the user must do so only while the core is idle, as the core does not
// enforce it; cfg_ready is always high. One instruction at a time is in
// flight. Each runs the wrap, read, execute and put steps, plus one wrap
// step per wrap of an out-of-range slot index; arithmetic, compare, negate
// and not also wait in the ALU step. The shared ALU runs one bit per cycle,
// and the stack RAM read takes its own step before execute.
// While an output beat is stalled, one more input beat can be taken and
// run; it then waits in its final step until the earlier beat leaves.
// Reset clears pc, stack pointer, slot valid bits and program_length, so
// the core reports done until a length is written.
// ----------------------------------------------------------------------------
module integer_stack_machine_core
  import ism_pkg::*;
#(
  parameter int STACK_DEPTH   = DEF_STACK_DEPTH,
  parameter int SLOT_COUNT    = DEF_SLOT_COUNT,
  parameter int PROGRAM_DEPTH = DEF_PROGRAM_DEPTH,
  localparam int SP_W = $clog2(STACK_DEPTH + 1),
  localparam int PC_W = $clog2(PROGRAM_DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [ACT_W-1:0]  action,
  input  logic [SLOT_W-1:0] slot_index,
  input  logic [TGT_W-1:0]  jump_target,
  input  logic [DATA_W-1:0] immediate,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [PC_W-1:0]   next_pc,
  output logic [DATA_W-1:0] top_value,
  output logic [SP_W-1:0]   stack_depth,
  output logic [1:0]        status,
  output logic              done_res
);

  localparam int SA_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int SL_AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CMP_W = (PC_W > CFG_W) ? PC_W : CFG_W;

  core_state_t        state, state_next;
  logic [ACT_W-1:0]   op_r;
  logic [SLOT_W-1:0]  slot_r;
  logic [TGT_W-1:0]   tgt_r;
  logic [DATA_W-1:0]  imm_r;
  logic [SP_W-1:0]    sp;
  logic [PC_W-1:0]    pc;
  logic [DATA_W-1:0]  tos;
  logic [CFG_W-1:0]   prog_len;
  logic [SLOT_COUNT-1:0] slot_valid;
  status_t            st_r, ex_status;

  logic [CMP_W-1:0]   pl_ext, len_eff;
  logic               run, ex_go, alu_use, op_bin, op_un, wrap_need, out_free;
  logic [PC_W-1:0]    pc_inc;
  logic [SL_AW-1:0]   slot_addr;
  logic [DATA_W-1:0]  slot_val;

  logic               stk_we;
  logic [SA_W-1:0]    stk_waddr, stk_raddr;
  logic [DATA_W-1:0]  stk_wdata, stk_rdata;
  logic               slt_we;
  logic [DATA_W-1:0]  slt_rdata;

  alu_req_t           alu_req;
  alu_rsp_t           alu_rsp;

  assign cfg_ready = 1'b1;
  assign pl_ext    = CMP_W'(prog_len);
  assign len_eff   = (pl_ext > CMP_W'(PROGRAM_DEPTH)) ? CMP_W'(PROGRAM_DEPTH) : pl_ext;
  assign run       = (CMP_W'(pc) < len_eff);
  assign pc_inc    = pc + PC_W'(1);
  assign slot_addr = SL_AW'(slot_r);
  assign slot_val  = slot_valid[slot_addr] ? slt_rdata : '0;
  assign wrap_need = (int'(slot_r) >= SLOT_COUNT);
  assign out_free  = !out_valid || !out_stall;
  assign op_bin    = (op_r >= OP_ADD) && (op_r <= OP_NE);
  assign op_un     = (op_r == OP_NEG) || (op_r == OP_NOT);

  always_comb begin
    ex_status = ST_OK;
    if (run) begin
      if ((op_r == OP_PUSH || op_r == OP_LOAD) && sp == SP_W'(STACK_DEPTH)) begin
        ex_status = ST_OVER;
      end else if ((op_r == OP_STORE_DECL || op_r == OP_STORE || op_un ||
                    op_r == OP_JUMP_FALSE) && sp == '0) begin
        ex_status = ST_UNDER;
      end else if (op_bin && sp < SP_W'(2)) begin
        ex_status = ST_UNDER;
      end else if ((op_r == OP_DIV || op_r == OP_MOD) && tos == '0) begin
        ex_status = ST_DIVZERO;
      end
    end
  end

  assign ex_go   = run && (ex_status == ST_OK);
  assign alu_use = ex_go && (op_bin || op_un);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_WRAP;
      S_WRAP: if (!wrap_need) state_next = S_READ;
      S_READ: state_next = S_EXEC;
      S_EXEC: state_next = alu_use ? S_ALU : S_PUT;
      S_ALU:  if (alu_rsp.done) state_next = S_PUT;
      S_PUT:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state != S_IDLE);
    stk_we    = 1'b0;
    stk_waddr = SA_W'(sp);
    stk_wdata = imm_r;
    stk_raddr = SA_W'(sp - SP_W'(2));
    slt_we    = (state == S_EXEC) && ex_go &&
                (op_r == OP_STORE_DECL || op_r == OP_STORE);
    alu_req.start = (state == S_EXEC) && alu_use;
    alu_req.a     = op_un ? tos : stk_rdata;
    alu_req.b     = tos;
    unique case (op_r)
      OP_ADD:  alu_req.op = ALU_ADD;
      OP_SUB:  alu_req.op = ALU_SUB;
      OP_MUL:  alu_req.op = ALU_MUL;
      OP_DIV:  alu_req.op = ALU_DIV;
      OP_MOD:  alu_req.op = ALU_MOD;
      OP_LT:   alu_req.op = ALU_LT;
      OP_LE:   alu_req.op = ALU_LE;
      OP_GT:   alu_req.op = ALU_GT;
      OP_GE:   alu_req.op = ALU_GE;
      OP_EQ:   alu_req.op = ALU_EQ;
      OP_NE:   alu_req.op = ALU_NE;
      OP_NEG:  alu_req.op = ALU_NEG;
      default: alu_req.op = ALU_NOT;
    endcase
    if (state == S_EXEC && ex_go && (op_r == OP_PUSH || op_r == OP_LOAD)) begin
      stk_we    = 1'b1;
      stk_wdata = (op_r == OP_PUSH) ? imm_r : slot_val;
    end else if (state == S_ALU && alu_rsp.done) begin
      // Binary ops replace the second entry, unary ops rewrite the top.
      stk_we    = 1'b1;
      stk_waddr = op_bin ? SA_W'(sp - SP_W'(2)) : SA_W'(sp - SP_W'(1));
      stk_wdata = alu_rsp.result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      sp         <= '0;
      pc         <= '0;
      prog_len   <= '0;
      slot_valid <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        prog_len <= cfg_data;
      end
      if (state == S_PUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_EXEC: begin
          if (ex_go && !alu_use) begin
            unique case (op_r)
              OP_PUSH, OP_LOAD: begin
                sp <= sp + SP_W'(1);
                pc <= pc_inc;
              end
              OP_STORE_DECL, OP_STORE: begin
                sp <= sp - SP_W'(1);
                slot_valid[slot_addr] <= 1'b1;
                pc <= pc_inc;
              end
              OP_JUMP: pc <= PC_W'(tgt_r);
              OP_JUMP_FALSE: begin
                sp <= sp - SP_W'(1);
                pc <= (tos == '0) ? PC_W'(tgt_r) : pc_inc;
              end
              default: pc <= pc_inc;
            endcase
          end
        end
        S_ALU: begin
          if (alu_rsp.done) begin
            if (op_bin) begin
              sp <= sp - SP_W'(1);
            end
            pc <= pc_inc;
          end
        end
        default: begin
          pc <= pc;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          op_r   <= action;
          slot_r <= slot_index;
          tgt_r  <= jump_target;
          imm_r  <= immediate;
        end
      end
      S_WRAP: if (wrap_need) slot_r <= slot_r - SLOT_W'(SLOT_COUNT);
      S_EXEC: begin
        st_r <= ex_status;
        if (ex_go && !alu_use) begin
          if (op_r == OP_PUSH) begin
            tos <= imm_r;
          end else if (op_r == OP_LOAD) begin
            tos <= slot_val;
          end else if (op_r == OP_STORE_DECL || op_r == OP_STORE ||
                       op_r == OP_JUMP_FALSE) begin
            tos <= stk_rdata;
          end
        end
      end
      S_ALU: if (alu_rsp.done) tos <= alu_rsp.result;
      S_PUT: begin
        if (out_free) begin
          next_pc     <= pc;
          top_value   <= (sp != '0) ? tos : '0;
          stack_depth <= sp;
          status      <= st_r;
          done_res    <= !run;
        end
      end
      default: begin
        tos <= tos;
      end
    endcase
  end

  ism_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  ism_ram #(
    .WIDTH (DATA_W),
    .DEPTH (SLOT_COUNT)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slt_we),
    .waddr (slot_addr),
    .wdata (tos),
    .raddr (slot_addr),
    .rdata (slt_rdata)
  );

  ism_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (alu_req),
    .rsp (alu_rsp)
  );

`ifndef SYNTHESIS
  a_sp_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= SP_W'(STACK_DEPTH))
    else $error("stack pointer beyond stack depth");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("core took a beat while still working on one");

  a_alu_handoff: assert property (@(posedge clk) disable iff (rst)
    alu_req.start |=> (state == S_ALU))
    else $error("ALU started without the sequencer waiting on it");

  a_error_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC && ex_status != ST_OK) |=> ($stable(pc) && $stable(sp)))
    else $error("error status changed pc or stack pointer");
`endif

endmodule
